// File: hdl/swhr_pkg.sv
// Shared types, constants and register codes for the single-wire sensor reader.
// No dependencies; every other file refers to it by scoped names.
package swhr_pkg;

    localparam int FRAME_BITS = 40;
    localparam int BIT_IDX_W  = 6;
    localparam int TICK_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_START_LOW  = 3'd1;
    localparam logic [2:0] PH_START_HIGH = 3'd2;
    localparam logic [2:0] PH_ACK_LOW    = 3'd3;
    localparam logic [2:0] PH_ACK_HIGH   = 3'd4;
    localparam logic [2:0] PH_BIT_LOW    = 3'd5;
    localparam logic [2:0] PH_BIT_HIGH   = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TIMEOUT  = 2'd1;
    localparam logic [1:0] ST_CHECKSUM = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd3;

    localparam logic [15:0] RST_START_LOW    = 16'd18000;
    localparam logic [7:0]  RST_RELEASE_HIGH = 8'd40;
    localparam logic [7:0]  RST_ONE_THRESH   = 8'd40;
    localparam logic [15:0] RST_TIMEOUT      = 16'd10000;

    typedef struct packed {
        logic start_req;
        logic line_level;
    } t_in;

    typedef struct packed {
        logic       drive_enable;
        logic       drive_level;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] temperature;
        logic [7:0] humidity;
    } t_out;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  release_high_ticks;
        logic [7:0]  one_threshold_ticks;
        logic [15:0] timeout_ticks;
    } t_cfg;

endpackage

// File: hdl/swhr_cfg_regs.sv
// Configuration register file for the single-wire sensor reader.
// Depends on swhr_pkg for the register codes, reset values and the t_cfg struct.
module swhr_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [swhr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [swhr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output swhr_pkg::t_cfg                  o_cfg
);

    swhr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_low_ticks     <= swhr_pkg::RST_START_LOW;
            r_cfg.release_high_ticks  <= swhr_pkg::RST_RELEASE_HIGH;
            r_cfg.one_threshold_ticks <= swhr_pkg::RST_ONE_THRESH;
            r_cfg.timeout_ticks       <= swhr_pkg::RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                swhr_pkg::CFG_START_LOW:    r_cfg.start_low_ticks     <= i_cfg_data;
                swhr_pkg::CFG_RELEASE_HIGH: r_cfg.release_high_ticks  <= i_cfg_data[7:0];
                swhr_pkg::CFG_ONE_THRESH:   r_cfg.one_threshold_ticks <= i_cfg_data[7:0];
                swhr_pkg::CFG_TIMEOUT:      r_cfg.timeout_ticks       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hdl/swhr_core.sv
// Reader state machine: phase, tick counter, bit counter and frame shift register.
// Depends on swhr_pkg; advances one tick whenever i_step is high.
module swhr_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  swhr_pkg::t_in  i_item,
    input  swhr_pkg::t_cfg i_cfg,
    output swhr_pkg::t_out o_res
);

    logic [2:0]                       r_phase, n_phase;
    logic [swhr_pkg::TICK_W-1:0]      r_tick, n_tick;
    logic [swhr_pkg::BIT_IDX_W-1:0]   r_bit_idx, n_bit_idx;
    logic [swhr_pkg::FRAME_BITS-1:0]  r_frame, n_frame;
    logic [7:0]                       r_temp, n_temp;
    logic [7:0]                       r_hum, n_hum;
    logic                             s_wait_lvl;
    logic                             s_bit;
    logic [7:0]                       s_b0, s_b2, s_b4;
    logic                             s_den, s_dlev, s_done;
    logic [1:0]                       s_status;

    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_bit_idx = r_bit_idx;
        n_frame   = r_frame;
        n_temp    = r_temp;
        n_hum     = r_hum;
        s_den     = 1'b0;
        s_dlev    = 1'b0;
        s_done    = 1'b0;
        s_status  = swhr_pkg::ST_OK;
        s_bit     = 1'b0;
        s_b0      = 8'd0;
        s_b2      = 8'd0;
        s_b4      = 8'd0;

        if (n_phase == swhr_pkg::PH_IDLE && i_item.start_req) begin
            n_phase   = swhr_pkg::PH_START_LOW;
            n_tick    = '0;
            n_bit_idx = '0;
            n_frame   = '0;
        end

        s_wait_lvl = !(n_phase == swhr_pkg::PH_ACK_LOW || n_phase == swhr_pkg::PH_BIT_LOW);

        case (n_phase)
            swhr_pkg::PH_START_LOW: begin
                s_den  = 1'b1;
                n_tick = n_tick + 1'b1;
                if (n_tick >= {1'b0, i_cfg.start_low_ticks}) begin
                    n_tick  = '0;
                    n_phase = (i_cfg.release_high_ticks == 8'd0) ?
                              swhr_pkg::PH_ACK_LOW : swhr_pkg::PH_START_HIGH;
                end
            end
            swhr_pkg::PH_START_HIGH: begin
                s_den  = 1'b1;
                s_dlev = 1'b1;
                n_tick = n_tick + 1'b1;
                if (n_tick >= {9'd0, i_cfg.release_high_ticks}) begin
                    n_tick  = '0;
                    n_phase = swhr_pkg::PH_ACK_LOW;
                end
            end
            swhr_pkg::PH_ACK_LOW, swhr_pkg::PH_ACK_HIGH,
            swhr_pkg::PH_BIT_LOW, swhr_pkg::PH_BIT_HIGH: begin
                if (i_item.line_level == s_wait_lvl) begin
                    n_tick = n_tick + 1'b1;
                    if (n_tick > {1'b0, i_cfg.timeout_ticks}) begin
                        s_done   = 1'b1;
                        s_status = swhr_pkg::ST_TIMEOUT;
                        n_phase  = swhr_pkg::PH_IDLE;
                        n_tick   = '0;
                    end
                end else if (n_phase == swhr_pkg::PH_ACK_LOW) begin
                    n_phase = swhr_pkg::PH_ACK_HIGH;
                    n_tick  = swhr_pkg::TICK_W'(1);
                end else if (n_phase == swhr_pkg::PH_ACK_HIGH) begin
                    n_phase = swhr_pkg::PH_BIT_LOW;
                    n_tick  = swhr_pkg::TICK_W'(1);
                end else if (n_phase == swhr_pkg::PH_BIT_LOW) begin
                    n_phase = swhr_pkg::PH_BIT_HIGH;
                    n_tick  = swhr_pkg::TICK_W'(1);
                end else begin
                    s_bit     = n_tick > {9'd0, i_cfg.one_threshold_ticks};
                    n_frame   = {n_frame[swhr_pkg::FRAME_BITS-2:0], s_bit};
                    n_bit_idx = n_bit_idx + 1'b1;
                    if (n_bit_idx >= swhr_pkg::BIT_IDX_W'(swhr_pkg::FRAME_BITS)) begin
                        s_b0      = n_frame[swhr_pkg::FRAME_BITS-1 -: 8];
                        s_b2      = n_frame[swhr_pkg::FRAME_BITS-17 -: 8];
                        s_b4      = n_frame[7:0];
                        n_temp    = s_b0;
                        n_hum     = s_b2;
                        s_done    = 1'b1;
                        s_status  = (8'(s_b0 + s_b2) == s_b4) ?
                                    swhr_pkg::ST_OK : swhr_pkg::ST_CHECKSUM;
                        n_phase   = swhr_pkg::PH_IDLE;
                        n_tick    = '0;
                        n_bit_idx = '0;
                    end else begin
                        n_phase = swhr_pkg::PH_BIT_LOW;
                        n_tick  = swhr_pkg::TICK_W'(1);
                    end
                end
            end
            default: begin
                n_phase = swhr_pkg::PH_IDLE;
                n_tick  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= swhr_pkg::PH_IDLE;
            r_tick    <= '0;
            r_bit_idx <= '0;
            r_frame   <= '0;
            r_temp    <= '0;
            r_hum     <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_bit_idx <= n_bit_idx;
            r_frame   <= n_frame;
            r_temp    <= n_temp;
            r_hum     <= n_hum;
        end
    end

    always_comb begin
        o_res.drive_enable = s_den;
        o_res.drive_level  = s_dlev;
        o_res.busy_res     = n_phase != swhr_pkg::PH_IDLE;
        o_res.done_res     = s_done;
        o_res.status       = s_status;
        o_res.temperature  = n_temp;
        o_res.humidity     = n_hum;
    end

endmodule

// File: hdl/single_wire_humidity_sensor_reader.sv
// Data path: a beat accepted into the input register is stepped by the reader when it
// advances, and its result beat is registered into the output register at that step.
// Throughput: one beat per cycle; while the result side stalls, one more beat is taken
// into the input register before the input stalls.
// Reset: synchronous, active low; clears both valids, the reader state and the
// configuration registers to their default values.
module single_wire_humidity_sensor_reader (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  swhr_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output swhr_pkg::t_out                  o_out_data,
    input  logic                            i_cfg_we,
    input  logic [swhr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [swhr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic           r_in_valid;
    swhr_pkg::t_in  r_in_data;
    logic           r_out_valid;
    swhr_pkg::t_out r_out_data;
    logic           w_adv;
    swhr_pkg::t_cfg w_cfg;
    swhr_pkg::t_out w_res;

    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;

    swhr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    swhr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_item  (r_in_data),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: hdl/swhr_checker.sv
// Port-level checks for the single-wire sensor reader, bound to the top level.
// Depends on swhr_pkg for the payload types and status codes.
module swhr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input swhr_pkg::t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("Result beat changed while stalled.");

    a_status_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.done_res |-> o_out_data.status == swhr_pkg::ST_OK)
        else $error("Nonzero status without done.");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |-> !o_out_data.busy_res)
        else $error("Reader still busy on the finishing beat.");

    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.drive_enable |-> o_out_data.busy_res)
        else $error("Line driven while the reader is not busy.");

    a_level_needs_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.drive_level |-> o_out_data.drive_enable)
        else $error("Drive level high without drive enable.");

endmodule

bind single_wire_humidity_sensor_reader swhr_checker u_swhr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// File: test/single_wire_humidity_sensor_reader_tb.sv
// Self-checking testbench for single_wire_humidity_sensor_reader: emulates the sensor
// tick by tick, predicts every result beat, and compares them under random gaps and stalls.
// Depends on swhr_pkg and the single_wire_humidity_sensor_reader RTL only.
module single_wire_humidity_sensor_reader_tb;

    localparam int LIMIT = 12_000_000;
    localparam int RANDOM_TICKS = 400;

    typedef struct {
        bit                             is_cfg;
        logic [swhr_pkg::CFG_IDX_W-1:0] idx;
        logic [15:0]                    val;
        logic                           s;
        logic                           l;
        bit                             typed;
        swhr_pkg::t_out                 want;
    } t_plan_row;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    swhr_pkg::t_in                   in_data;
    logic                            out_valid;
    logic                            out_stall;
    swhr_pkg::t_out                  out_data;
    logic                            cfg_we;
    logic [swhr_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [swhr_pkg::CFG_DATA_W-1:0] cfg_data;

    // Predictor copy of the reader.
    swhr_pkg::t_cfg rd_cfg;
    logic [2:0]     rd_phase;
    int unsigned    rd_count;
    int unsigned    rd_bits;
    logic [39:0]    rd_shift;
    logic [7:0]     rd_temp;
    logic [7:0]     rd_hum;

    swhr_pkg::t_out reading_q[$];
    swhr_pkg::t_out head;
    t_plan_row      plan[$];

    int n_errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_good = 0;
    int n_csum = 0;
    int n_tmo = 0;
    int n_settings = 0;
    int send_calm = 0;
    int cycle_cnt = 0;
    bit pressure_done = 0;

    single_wire_humidity_sensor_reader DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("single_wire_humidity_sensor_reader regression: fail");
            $finish;
        end
    end

    function automatic int cap(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    // One sampling tick of the reader, updating the predictor state.
    task automatic sensor_tick(input swhr_pkg::t_in d, output swhr_pkg::t_out r);
        logic waiting;
        logic [7:0] b0;
        logic [7:0] b2;
        logic [7:0] b4;
        r = '0;
        if (rd_phase == swhr_pkg::PH_IDLE && d.start_req) begin
            rd_phase = swhr_pkg::PH_START_LOW;
            rd_count = 0;
            rd_bits = 0;
            rd_shift = '0;
        end
        case (rd_phase)
            swhr_pkg::PH_START_LOW: begin
                r.drive_enable = 1'b1;
                rd_count++;
                if (rd_count >= rd_cfg.start_low_ticks) begin
                    rd_count = 0;
                    rd_phase = (rd_cfg.release_high_ticks == 0) ?
                               swhr_pkg::PH_ACK_LOW : swhr_pkg::PH_START_HIGH;
                end
            end
            swhr_pkg::PH_START_HIGH: begin
                r.drive_enable = 1'b1;
                r.drive_level = 1'b1;
                rd_count++;
                if (rd_count >= rd_cfg.release_high_ticks) begin
                    rd_count = 0;
                    rd_phase = swhr_pkg::PH_ACK_LOW;
                end
            end
            swhr_pkg::PH_ACK_LOW, swhr_pkg::PH_ACK_HIGH,
            swhr_pkg::PH_BIT_LOW, swhr_pkg::PH_BIT_HIGH: begin
                waiting = (rd_phase == swhr_pkg::PH_ACK_HIGH ||
                           rd_phase == swhr_pkg::PH_BIT_HIGH);
                if (d.line_level == waiting) begin
                    rd_count++;
                    if (rd_count > rd_cfg.timeout_ticks) begin
                        r.done_res = 1'b1;
                        r.status = swhr_pkg::ST_TIMEOUT;
                        rd_phase = swhr_pkg::PH_IDLE;
                        rd_count = 0;
                    end
                end else if (rd_phase == swhr_pkg::PH_ACK_LOW) begin
                    rd_phase = swhr_pkg::PH_ACK_HIGH;
                    rd_count = 1;
                end else if (rd_phase == swhr_pkg::PH_ACK_HIGH) begin
                    rd_phase = swhr_pkg::PH_BIT_LOW;
                    rd_count = 1;
                end else if (rd_phase == swhr_pkg::PH_BIT_LOW) begin
                    rd_phase = swhr_pkg::PH_BIT_HIGH;
                    rd_count = 1;
                end else begin
                    rd_shift = {rd_shift[38:0], (rd_count > rd_cfg.one_threshold_ticks)};
                    rd_bits++;
                    if (rd_bits >= swhr_pkg::FRAME_BITS) begin
                        b0 = rd_shift[39:32];
                        b2 = rd_shift[23:16];
                        b4 = rd_shift[7:0];
                        rd_temp = b0;
                        rd_hum = b2;
                        r.done_res = 1'b1;
                        r.status = (8'(b0 + b2) == b4) ?
                                   swhr_pkg::ST_OK : swhr_pkg::ST_CHECKSUM;
                        rd_phase = swhr_pkg::PH_IDLE;
                        rd_count = 0;
                        rd_bits = 0;
                    end else begin
                        rd_phase = swhr_pkg::PH_BIT_LOW;
                        rd_count = 1;
                    end
                end
            end
            default: begin
                rd_phase = swhr_pkg::PH_IDLE;
                rd_count = 0;
            end
        endcase
        r.busy_res = (rd_phase != swhr_pkg::PH_IDLE);
        r.temperature = rd_temp;
        r.humidity = rd_hum;
    endtask

    // Offers one beat, waits for it to be taken, then maybe leaves a gap.
    task automatic send_tick(input logic s, input logic l, input bit typed,
                             input swhr_pkg::t_out want);
        swhr_pkg::t_in  d;
        swhr_pkg::t_out got;
        int             gap;
        int             r;
        d.start_req = s;
        d.line_level = l;
        in_data <= d;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        sensor_tick(d, got);
        reading_q.push_back(typed ? want : got);
        n_items++;
        @(negedge clk);
        gap = 0;
        if (send_calm > 0) begin
            send_calm--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 3) send_calm = $urandom_range(20, 150);
            else if (r >= 96) gap = $urandom_range(8, 30);
            else if (r >= 70) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic tick(input logic s, input logic l);
        send_tick(s, l, 1'b0, '0);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (reading_q.size() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [swhr_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        case (idx)
            swhr_pkg::CFG_START_LOW:    rd_cfg.start_low_ticks = val;
            swhr_pkg::CFG_RELEASE_HIGH: rd_cfg.release_high_ticks = val[7:0];
            swhr_pkg::CFG_ONE_THRESH:   rd_cfg.one_threshold_ticks = val[7:0];
            swhr_pkg::CFG_TIMEOUT:      rd_cfg.timeout_ticks = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int sl, input int rh, input int th, input int to);
        drain();
        write_reg(swhr_pkg::CFG_START_LOW, 16'(sl));
        write_reg(swhr_pkg::CFG_RELEASE_HIGH, 16'(rh));
        write_reg(swhr_pkg::CFG_ONE_THRESH, 16'(th));
        write_reg(swhr_pkg::CFG_TIMEOUT, 16'(to));
        n_settings++;
    endtask

    // Plays the sensor side of one reading; a fault bit index stretches that bit into a timeout.
    task automatic read_frame(input logic [39:0] frame, input int fault_bit);
        int tmo;
        int thr;
        int h;
        tmo = rd_cfg.timeout_ticks;
        thr = rd_cfg.one_threshold_ticks;
        tick(1'b1, 1'($urandom));
        while (rd_phase == swhr_pkg::PH_START_LOW || rd_phase == swhr_pkg::PH_START_HIGH)
            tick(1'($urandom), 1'($urandom));
        repeat ($urandom_range(1, cap(tmo, 6))) tick(1'($urandom), 1'b0);
        repeat ($urandom_range(1, cap(tmo, 6))) tick(1'($urandom), 1'b1);
        for (int i = 0; i < swhr_pkg::FRAME_BITS; i++) begin
            repeat ($urandom_range(1, cap(tmo, 3))) tick(1'($urandom), 1'b0);
            if (i == fault_bit) begin
                repeat (tmo + 1) tick(1'($urandom), 1'b1);
                return;
            end
            if (frame[39-i] && thr < tmo) h = $urandom_range(thr + 1, cap(tmo, thr + 3));
            else h = $urandom_range(1, cap(cap(thr, tmo), 4));
            repeat (h) tick(1'($urandom), 1'b1);
        end
        tick(1'($urandom), 1'b0);
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 6)) tick(1'b0, 1'($urandom));
        if (rd_cfg.start_low_ticks < 100 && rd_cfg.timeout_ticks < 100 &&
            $urandom_range(0, 3) == 0) begin
            tick(1'b1, 1'($urandom));
            while (rd_phase != swhr_pkg::PH_IDLE) tick(1'($urandom), 1'($urandom));
        end
    endtask

    function automatic t_plan_row cfg_row(input logic [swhr_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [15:0] val);
        t_plan_row r;
        r = '{is_cfg: 1'b1, idx: idx, val: val, s: 1'b0, l: 1'b0, typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic t_plan_row tick_row(input logic s, input logic l);
        t_plan_row r;
        r = '{is_cfg: 1'b0, idx: '0, val: '0, s: s, l: l, typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic t_plan_row fixed_row(input logic s, input logic l, input logic den,
                                            input logic dlev, input logic busy, input logic done,
                                            input logic [1:0] st);
        t_plan_row r;
        r = tick_row(s, l);
        r.typed = 1'b1;
        r.want.drive_enable = den;
        r.want.drive_level = dlev;
        r.want.busy_res = busy;
        r.want.done_res = done;
        r.want.status = st;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (reading_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, got %h", $time, out_data);
                n_errors++;
            end else begin
                head = reading_q.pop_front();
                check_field("drive_enable", 8'(head.drive_enable), 8'(out_data.drive_enable));
                check_field("drive_level", 8'(head.drive_level), 8'(out_data.drive_level));
                check_field("busy", 8'(head.busy_res), 8'(out_data.busy_res));
                check_field("done", 8'(head.done_res), 8'(out_data.done_res));
                check_field("status", 8'(head.status), 8'(out_data.status));
                check_field("temperature", head.temperature, out_data.temperature);
                check_field("humidity", head.humidity, out_data.humidity);
                n_results++;
                if (head.done_res) begin
                    case (head.status)
                        swhr_pkg::ST_OK:       n_good++;
                        swhr_pkg::ST_TIMEOUT:  n_tmo++;
                        swhr_pkg::ST_CHECKSUM: n_csum++;
                        default: ;
                    endcase
                end
            end
        end
    end

    // Result side: random stalls, calm stretches, and one long hold once traffic is flowing.
    initial begin
        int hold;
        int calm;
        int r;
        logic nxt;
        hold = 0;
        calm = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            nxt = 1'b0;
            if (hold > 0) begin
                nxt = 1'b1;
                hold--;
            end else if (!pressure_done && n_results >= 200) begin
                pressure_done = 1'b1;
                nxt = 1'b1;
                hold = 59;
            end else if (calm > 0) begin
                calm--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    calm = $urandom_range(20, 200);
                end else if (r < 24) begin
                    nxt = 1'b1;
                    hold = $urandom_range(0, 2);
                end else if (r < 27) begin
                    nxt = 1'b1;
                    hold = $urandom_range(9, 29);
                end
            end
            out_stall <= nxt;
        end
    end

    initial begin
        logic [7:0] b0;
        logic [7:0] b2;
        logic [7:0] b4;
        int base;
        int th;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        rd_cfg = '{swhr_pkg::RST_START_LOW, swhr_pkg::RST_RELEASE_HIGH,
                   swhr_pkg::RST_ONE_THRESH, swhr_pkg::RST_TIMEOUT};
        rd_phase = swhr_pkg::PH_IDLE;
        rd_count = 0;
        rd_bits = 0;
        rd_shift = '0;
        rd_temp = '0;
        rd_hum = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        plan.push_back(fixed_row(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, swhr_pkg::ST_OK));
        plan.push_back(cfg_row(swhr_pkg::CFG_START_LOW, 16'd2));
        plan.push_back(cfg_row(swhr_pkg::CFG_RELEASE_HIGH, 16'd1));
        plan.push_back(cfg_row(swhr_pkg::CFG_ONE_THRESH, 16'd1));
        plan.push_back(cfg_row(swhr_pkg::CFG_TIMEOUT, 16'd1));
        plan.push_back(fixed_row(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, swhr_pkg::ST_OK));
        plan.push_back(fixed_row(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, swhr_pkg::ST_OK));
        plan.push_back(fixed_row(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, swhr_pkg::ST_OK));
        plan.push_back(fixed_row(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, swhr_pkg::ST_OK));
        plan.push_back(tick_row(1'b0, 1'b0));
        plan.push_back(fixed_row(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, swhr_pkg::ST_TIMEOUT));
        plan.push_back(tick_row(1'b1, 1'b1));
        plan.push_back(tick_row(1'b0, 1'b0));
        plan.push_back(tick_row(1'b0, 1'b1));
        plan.push_back(tick_row(1'b0, 1'b1));
        plan.push_back(tick_row(1'b1, 1'b0));
        plan.push_back(tick_row(1'b0, 1'b1));
        plan.push_back(fixed_row(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, swhr_pkg::ST_TIMEOUT));
        // A zero start length still drives one tick, and a zero release skips the high drive.
        plan.push_back(cfg_row(swhr_pkg::CFG_START_LOW, 16'd0));
        plan.push_back(cfg_row(swhr_pkg::CFG_RELEASE_HIGH, 16'd0));
        plan.push_back(fixed_row(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, swhr_pkg::ST_OK));
        plan.push_back(tick_row(1'b0, 1'b0));
        plan.push_back(fixed_row(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, swhr_pkg::ST_TIMEOUT));

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                drain();
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                send_tick(plan[i].s, plan[i].l, plan[i].typed, plan[i].want);
            end
        end

        apply_settings(4, 2, 3, 12);
        read_frame(40'hFF_FF_FF_FF_FE, -1);
        read_frame(40'h12_34_56_78_00, -1);
        read_frame(40'hA5_00_5A_00_FF, 17);
        apply_settings(1, 255, 255, 65535);
        read_frame(40'h00_00_00_00_00, -1);
        apply_settings(200, 0, 1, 1);
        read_frame(40'h00_00_00_00_00, -1);

        base = n_items;
        while (n_items - base < RANDOM_TICKS) begin
            th = $urandom_range(1, 8);
            if ($urandom_range(0, 4) == 0)
                apply_settings($urandom_range(1, 6), $urandom_range(0, 4), th,
                               $urandom_range(1, 3));
            else
                apply_settings($urandom_range(1, 6), $urandom_range(0, 4), th,
                               th + $urandom_range(2, 10));
            repeat ($urandom_range(1, 3)) begin
                noise_burst();
                b0 = 8'($urandom);
                b2 = 8'($urandom);
                b4 = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'(b0 + b2);
                read_frame({b0, 8'($urandom), b2, 8'($urandom), b4},
                           ($urandom_range(0, 4) == 0) ? $urandom_range(0, 39) : -1);
            end
        end

        drain();
        repeat (5) @(negedge clk);
        $display("Ran %0d ticks under %0d register settings with random gaps and stalls.",
                 n_items, n_settings);
        $display("Readings seen: %0d clean, %0d checksum errors, %0d timeouts; %0d mismatches.",
                 n_good, n_csum, n_tmo, n_errors);
        if (n_errors == 0 && reading_q.size() == 0) begin
            $display("single_wire_humidity_sensor_reader regression: pass");
        end else begin
            $display("single_wire_humidity_sensor_reader regression: fail");
        end
        $finish;
    end

endmodule
